// File: design/sst_pkg.sv
// Shared types, constants and the syscall classifier of the syscall threat tracker.
// Used by syscall_threat_tracker; depends on nothing else.
package sst_pkg;

   // Default sizes handed to the top level.
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int ID_BITS_DEF     = 22;

   // Saturation bound of the 24-bit score and sleep counters.
   localparam logic [23:0] SAT24 = 24'hFF_FFFF;

   // Reset values of the configuration registers.
   localparam logic [15:0] EVENT_LIMIT_RST   = 16'd1024;
   localparam logic [7:0]  PTS_READ_RST      = 8'd5;
   localparam logic [7:0]  PTS_WRITE_RST     = 8'd10;
   localparam logic [7:0]  PTS_DELETE_RST    = 8'd20;
   localparam logic [7:0]  PTS_EXEC_RST      = 8'd30;
   localparam logic [7:0]  PTS_CONNECT_RST   = 8'd50;
   localparam logic [7:0]  PTS_SLEEP_RST     = 8'd5;

   // x86_64 syscall numbers of interest.
   localparam logic [8:0] NR_WRITE           = 9'd1;
   localparam logic [8:0] NR_OPEN            = 9'd2;
   localparam logic [8:0] NR_PAUSE           = 9'd34;
   localparam logic [8:0] NR_NANOSLEEP       = 9'd35;
   localparam logic [8:0] NR_CONNECT         = 9'd42;
   localparam logic [8:0] NR_EXECVE          = 9'd59;
   localparam logic [8:0] NR_UNLINK          = 9'd87;
   localparam logic [8:0] NR_CLOCK_NANOSLEEP = 9'd230;
   localparam logic [8:0] NR_OPENAT          = 9'd257;

   // Syscall classes as reported on the result channel.
   typedef enum logic [2:0] {
      CLS_NONE    = 3'd0,
      CLS_READ    = 3'd1,
      CLS_WRITE   = 3'd2,
      CLS_DELETE  = 3'd3,
      CLS_EXEC    = 3'd4,
      CLS_CONNECT = 3'd5,
      CLS_SLEEP   = 3'd6
   } class_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_EVENT_LIMIT   = 3'd0,
      REG_PTS_READ      = 3'd1,
      REG_PTS_WRITE     = 3'd2,
      REG_PTS_DELETE    = 3'd3,
      REG_PTS_EXEC      = 3'd4,
      REG_PTS_CONNECT   = 3'd5,
      REG_PTS_SLEEP     = 3'd6
   } reg_idx_type;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   // Map a syscall number to its class.
   function automatic class_type classify(input logic [8:0] nr);
      class_type cls;
      unique case (nr) inside
         NR_OPEN, NR_OPENAT:                        cls = CLS_READ;
         NR_WRITE:                                  cls = CLS_WRITE;
         NR_UNLINK:                                 cls = CLS_DELETE;
         NR_EXECVE:                                 cls = CLS_EXEC;
         NR_CONNECT:                                cls = CLS_CONNECT;
         NR_NANOSLEEP, NR_CLOCK_NANOSLEEP, NR_PAUSE: cls = CLS_SLEEP;
         default:                                   cls = CLS_NONE;
      endcase
      return cls;
   endfunction

endpackage

// File: design/syscall_threat_tracker.sv
// Syscall threat tracker: id table search, entry/exit tracking and threat scoring.
// Depends on sst_pkg for types, constants and the syscall classifier.
//
// Usage:
//   Input beat: drive req_proc_id and req_syscall_num with start high; the beat
//   is taken at a rising edge where start is high and busy is low. busy stays
//   high while the item is worked on.
//   Result beat: rsp_valid is high for exactly one cycle with all rsp_ fields;
//   the receiver cannot stall, so every result is taken in that cycle.
//   Search: the id table lives in one memory, scanned one entry per cycle by a
//   single shared comparator behind the registered read port. Slots are read in
//   order until the id matches or all stored ids are read; a miss then lets
//   the compare pipe drain before the update step. The result strobe comes in
//   the first cycle with busy low, and a new beat may be taken then.
//   Configuration: APB-style port, register i at byte address 4*i, pready always
//   high; reads return the value. Written only while idle: a user rule, unenforced.
//   Reset (synchronous, active high) empties the table, clears the counters,
//   score and timebomb flag, and loads the register defaults. No clearing pass
//   is needed: only slots below the fill count are ever read.
module syscall_threat_tracker
   import sst_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ID_BITS     = ID_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // Input channel
   input  logic               start,
   output logic               busy,
   input  logic [ID_BITS-1:0] req_proc_id,
   input  logic [8:0]         req_syscall_num,
   // Result channel
   output logic               rsp_valid,
   output logic               rsp_tracked,
   output logic               rsp_is_entry,
   output logic [2:0]         rsp_class_code,
   output logic [7:0]         rsp_awarded,
   output logic               rsp_logged,
   output logic [23:0]        rsp_threat_total,
   output logic [15:0]        rsp_events_logged,
   output logic [23:0]        rsp_sleep_calls,
   output logic               rsp_timebomb,
   // Configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_W = ID_BITS + 1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   // Table memory: each word holds the in-call bit over the process id.
   logic [WORD_W-1:0] entry_mem [TABLE_DEPTH];
   logic [WORD_W-1:0] mem_rdata_ff;
   logic              mem_re;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   // Sequencer and search registers.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [ADDR_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic               found_ff, found_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;
   logic               in_call_ff, in_call_in;
   logic [ID_BITS-1:0] proc_ff, proc_in;
   logic [8:0]         nr_ff, nr_in;

   // Running state.
   logic [CNT_W-1:0] id_count_ff, id_count_in;
   logic [15:0]      event_ff, event_in;
   logic [23:0]      score_ff, score_in;
   logic [23:0]      sleep_ff, sleep_in;
   logic             timebomb_ff, timebomb_in;

   // Configuration registers.
   logic [15:0] limit_ff;
   logic [7:0]  pts_read_ff, pts_write_ff, pts_delete_ff;
   logic [7:0]  pts_exec_ff, pts_connect_ff, pts_sleep_ff;

   // Result registers.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       tracked_ff, tracked_in;
   logic       entry_ff, entry_in;
   class_type  class_ff, class_in;
   logic [7:0] awarded_ff, awarded_in;
   logic       logged_ff, logged_in;

   // Update-step helpers.
   logic        match;
   logic        room;
   logic        upd_tracked;
   logic        upd_entry;
   class_type   upd_class;
   logic [7:0]  points;
   logic [24:0] score_sum;
   logic        accept;
   logic        csr_wr;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   // The shared comparator: stored id against the searched id.
   assign match = cmp_valid_ff && (mem_rdata_ff[ID_BITS-1:0] == proc_ff);
   assign room  = (id_count_ff < DEPTH_C);

   // Outcome of the search; a newly registered id counts as an entry.
   assign upd_tracked = found_ff || room;
   assign upd_entry   = upd_tracked && (!found_ff || !in_call_ff);
   assign upd_class   = upd_entry ? classify(nr_ff) : CLS_NONE;

   // Points of the class chosen in the update step.
   always_comb begin
      case (upd_class)
         CLS_READ:    points = pts_read_ff;
         CLS_WRITE:   points = pts_write_ff;
         CLS_DELETE:  points = pts_delete_ff;
         CLS_EXEC:    points = pts_exec_ff;
         CLS_CONNECT: points = pts_connect_ff;
         CLS_SLEEP:   points = pts_sleep_ff;
         default:     points = 8'd0;
      endcase
   end

   assign score_sum = {1'b0, score_ff} + 25'(points);

   // Sequencer: capture, linear search, then one update step.
   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      in_call_in   = in_call_ff;
      proc_in      = proc_ff;
      nr_in        = nr_ff;
      id_count_in  = id_count_ff;
      event_in     = event_ff;
      score_in     = score_ff;
      sleep_in     = sleep_ff;
      timebomb_in  = timebomb_ff;
      rsp_valid_in = 1'b0;
      tracked_in   = tracked_ff;
      entry_in     = entry_ff;
      class_in     = CLS_NONE;
      awarded_in   = awarded_ff;
      logged_in    = logged_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = {1'b1, proc_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               proc_in      = req_proc_id;
               nr_in        = req_syscall_num;
               rd_idx_in    = '0;
               cmp_valid_in = 1'b0;
               found_in     = 1'b0;
               state_in     = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (match) begin
               found_in   = 1'b1;
               slot_in    = cmp_idx_ff;
               in_call_in = mem_rdata_ff[ID_BITS];
               state_in   = ST_UPDATE;
            end else if (rd_idx_ff < id_count_ff) begin
               // Issue the next read; its compare works on the registered read data.
               mem_re       = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = rd_idx_ff[ADDR_W-1:0];
               rd_idx_in    = CNT_W'(rd_idx_ff + 1'b1);
            end else if (cmp_valid_ff) begin
               // Last compare missed; let the pipe drain.
               cmp_valid_in = 1'b0;
            end else begin
               found_in = 1'b0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            tracked_in = upd_tracked;
            entry_in   = upd_entry;
            class_in   = upd_class;
            awarded_in = points;
            logged_in  = (points != 8'd0) && (event_ff < limit_ff);
            if (upd_class == CLS_SLEEP) begin
               timebomb_in = 1'b1;
               if (sleep_ff != SAT24) begin
                  sleep_in = sleep_ff + 24'd1;
               end
            end
            if (logged_in) begin
               score_in = score_sum[24] ? SAT24 : score_sum[23:0];
               event_in = event_ff + 16'd1;
            end
            // Toggle the in-call bit, or register the new id as in a call if the table has room.
            if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = slot_ff;
               mem_wdata = {!in_call_ff, proc_ff};
            end else if (room) begin
               mem_we      = 1'b1;
               mem_waddr   = id_count_ff[ADDR_W-1:0];
               mem_wdata   = {1'b1, proc_ff};
               id_count_in = CNT_W'(id_count_ff + 1'b1);
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Table memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= entry_mem[rd_idx_ff[ADDR_W-1:0]];
      end
   end

   // Control and running state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_valid_ff <= 1'b0;
         id_count_ff  <= '0;
         event_ff     <= '0;
         score_ff     <= '0;
         sleep_ff     <= '0;
         timebomb_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         id_count_ff  <= id_count_in;
         event_ff     <= event_in;
         score_ff     <= score_in;
         sleep_ff     <= sleep_in;
         timebomb_ff  <= timebomb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff   <= found_in;
      slot_ff    <= slot_in;
      in_call_ff <= in_call_in;
      proc_ff    <= proc_in;
      nr_ff      <= nr_in;
      if (state_ff == ST_UPDATE) begin
         tracked_ff <= tracked_in;
         entry_ff   <= entry_in;
         class_ff   <= class_in;
         awarded_ff <= awarded_in;
         logged_ff  <= logged_in;
      end
   end

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= EVENT_LIMIT_RST;
         pts_read_ff    <= PTS_READ_RST;
         pts_write_ff   <= PTS_WRITE_RST;
         pts_delete_ff  <= PTS_DELETE_RST;
         pts_exec_ff    <= PTS_EXEC_RST;
         pts_connect_ff <= PTS_CONNECT_RST;
         pts_sleep_ff   <= PTS_SLEEP_RST;
      end else if (csr_wr) begin
         unique case (reg_idx_type'(paddr[4:2]))
            REG_EVENT_LIMIT: limit_ff       <= pwdata[15:0];
            REG_PTS_READ:    pts_read_ff    <= pwdata[7:0];
            REG_PTS_WRITE:   pts_write_ff   <= pwdata[7:0];
            REG_PTS_DELETE:  pts_delete_ff  <= pwdata[7:0];
            REG_PTS_EXEC:    pts_exec_ff    <= pwdata[7:0];
            REG_PTS_CONNECT: pts_connect_ff <= pwdata[7:0];
            REG_PTS_SLEEP:   pts_sleep_ff   <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Configuration readback.
   always_comb begin
      unique case (reg_idx_type'(paddr[4:2]))
         REG_EVENT_LIMIT: prdata = {16'd0, limit_ff};
         REG_PTS_READ:    prdata = {24'd0, pts_read_ff};
         REG_PTS_WRITE:   prdata = {24'd0, pts_write_ff};
         REG_PTS_DELETE:  prdata = {24'd0, pts_delete_ff};
         REG_PTS_EXEC:    prdata = {24'd0, pts_exec_ff};
         REG_PTS_CONNECT: prdata = {24'd0, pts_connect_ff};
         REG_PTS_SLEEP:   prdata = {24'd0, pts_sleep_ff};
         default:         prdata = 32'd0;
      endcase
   end

   // Result beat.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tracked       = tracked_ff;
   assign rsp_is_entry      = entry_ff;
   assign rsp_class_code    = class_ff;
   assign rsp_awarded       = awarded_ff;
   assign rsp_logged        = logged_ff;
   assign rsp_threat_total  = score_ff;
   assign rsp_events_logged = event_ff;
   assign rsp_sleep_calls   = sleep_ff;
   assign rsp_timebomb      = timebomb_ff;

`ifndef NO_ASSERTIONS
   // An accepted beat always takes the block out of idle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted beat did not raise busy");

   // The strobe comes right after the update step, with the block idle again.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(state_ff == ST_UPDATE))
      else $error("result strobe outside the update hand-off");

   // A logged event is a tracked entry with nonzero points and a nonzero count.
   a_logged_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_logged |-> rsp_tracked && rsp_is_entry &&
                                  (rsp_awarded != 8'd0) && (rsp_events_logged != 16'd0))
      else $error("logged event without a scored entry");

   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      id_count_ff <= DEPTH_C)
      else $error("id count beyond table depth");
`endif

endmodule
